// ----- design/tlnsf_pkg.sv -----
// Package with the shared constants, types and codes of the line number squeeze filter.
`timescale 1ns / 1ps

package tlnsf_pkg;

   localparam int COUNT_DIGITS = 10;
   localparam int MIN_WIDTH    = 6;

   localparam int DIGIT_IDX_W = $clog2(COUNT_DIGITS);
   localparam int MAX_LEN     = (COUNT_DIGITS > MIN_WIDTH) ? COUNT_DIGITS : MIN_WIDTH;
   localparam int POS_W       = $clog2(MAX_LEN + 2);

   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;
   localparam logic [7:0] TAB_BYTE     = 8'd9;
   localparam logic [7:0] SPACE_BYTE   = 8'd32;
   localparam logic [7:0] ZERO_CHAR    = 8'd48;

   localparam logic [0:0] REG_NUMBER_MODE = 1'b0;
   localparam logic [0:0] REG_SQUEEZE_EN  = 1'b1;

   typedef logic [3:0] digit_type;
   typedef digit_type [COUNT_DIGITS-1:0] digits_type;

   typedef struct packed {
      logic [1:0] number_mode;
      logic       squeeze_en;
   } cfg_type;

   typedef struct packed {
      logic             keep;
      logic             numbered;
      logic [7:0]       in_byte;
      logic [POS_W-1:0] len;
      logic [POS_W-1:0] pad;
      digits_type       digits;
   } item_type;

endpackage

// ----- design/tlnsf_csr.sv -----
// Configuration register block with an APB-style write and read port.
`timescale 1ns / 1ps

module tlnsf_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tlnsf_pkg::PADDR_W-1:0]   paddr,
   input  logic [tlnsf_pkg::PDATA_W-1:0]   pwdata,
   output logic [tlnsf_pkg::PDATA_W-1:0]   prdata,
   output logic                            pready,
   output tlnsf_pkg::cfg_type              cfg
);
   import tlnsf_pkg::*;

   logic [1:0] number_mode_ff;
   logic [1:0] number_mode_in;
   logic       squeeze_en_ff;
   logic       squeeze_en_in;
   logic [0:0] reg_index;
   logic       wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[2:2];
   assign wr_en     = psel && penable && pwrite;

   always_comb begin
      number_mode_in = number_mode_ff;
      squeeze_en_in  = squeeze_en_ff;
      prdata         = '0;
      unique case (reg_index)
         REG_NUMBER_MODE: begin
            prdata = {{(PDATA_W-2){1'b0}}, number_mode_ff};
            if (wr_en) begin
               number_mode_in = pwdata[1:0];
            end
         end
         REG_SQUEEZE_EN: begin
            prdata = {{(PDATA_W-1){1'b0}}, squeeze_en_ff};
            if (wr_en) begin
               squeeze_en_in = pwdata[0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         number_mode_ff <= 2'd0;
         squeeze_en_ff  <= 1'b0;
      end else begin
         number_mode_ff <= number_mode_in;
         squeeze_en_ff  <= squeeze_en_in;
      end
   end

   assign cfg.number_mode = number_mode_ff;
   assign cfg.squeeze_en  = squeeze_en_ff;

endmodule

// ----- design/tlnsf_line_state.sv -----
// Line state: BCD line counter, line start and blank line flags, and per-byte decisions.
`timescale 1ns / 1ps

module tlnsf_line_state (
   input  logic                clock,
   input  logic                reset,
   input  tlnsf_pkg::cfg_type  cfg,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   output tlnsf_pkg::item_type item
);
   import tlnsf_pkg::*;

   digits_type           digits_ff;
   digits_type           digits_in;
   logic                 at_line_start_ff;
   logic                 at_line_start_in;
   logic                 prev_blank_ff;
   logic                 prev_blank_in;
   logic                 is_nl;
   logic                 empty_line;
   logic                 number_it;
   logic                 numbered;
   logic                 drop;
   logic                 carry;
   logic [DIGIT_IDX_W-1:0] top;
   logic [POS_W-1:0]     sig_len;
   logic [POS_W-1:0]     len;

   assign is_nl      = (in_byte == NEWLINE_BYTE);
   assign empty_line = at_line_start_ff && is_nl;
   assign number_it  = cfg.number_mode[1] ? !is_nl : cfg.number_mode[0];
   assign numbered   = at_line_start_ff && number_it;
   assign drop       = cfg.squeeze_en && empty_line && prev_blank_ff;

   always_comb begin
      top = '0;
      for (int i = 1; i < COUNT_DIGITS; i++) begin
         if (digits_ff[i] != 4'd0) begin
            top = DIGIT_IDX_W'(i);
         end
      end
      sig_len = POS_W'(top) + POS_W'(1);
      len     = (sig_len > POS_W'(MIN_WIDTH)) ? sig_len : POS_W'(MIN_WIDTH);
   end

   always_comb begin
      carry = 1'b1;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         digits_in[i] = digits_ff[i];
         if (carry) begin
            if (digits_ff[i] >= 4'd9) begin
               digits_in[i] = 4'd0;
            end else begin
               digits_in[i] = digits_ff[i] + 4'd1;
               carry        = 1'b0;
            end
         end
      end
   end

   assign at_line_start_in = is_nl;
   assign prev_blank_in    = empty_line;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COUNT_DIGITS; i++) begin
            digits_ff[i] <= (i == 0) ? 4'd1 : 4'd0;
         end
         at_line_start_ff <= 1'b1;
         prev_blank_ff    <= 1'b0;
      end else if (accept && !drop) begin
         if (numbered) begin
            digits_ff <= digits_in;
         end
         at_line_start_ff <= at_line_start_in;
         prev_blank_ff    <= prev_blank_in;
      end
   end

   assign item.keep     = !drop;
   assign item.numbered = numbered;
   assign item.in_byte  = in_byte;
   assign item.len      = len;
   assign item.pad      = len - sig_len;
   assign item.digits   = digits_ff;

endmodule

// ----- design/tlnsf_emit.sv -----
// Emitter: holds one accepted byte and sends its padding, digits, tab and byte to the output register.
`timescale 1ns / 1ps

module tlnsf_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tlnsf_pkg::item_type item,
   output logic                accept,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last
);
   import tlnsf_pkg::*;

   logic             item_valid_ff;
   logic             item_valid_in;
   item_type         item_ff;
   item_type         item_in;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [7:0]       out_byte_ff;
   logic [7:0]       out_byte_in;
   logic             last_ff;
   logic             last_in;
   logic             out_free;
   logic             final_char;
   logic             advance;
   logic             item_done;
   logic [POS_W-1:0] digit_idx;
   digit_type        digit;
   logic [7:0]       char;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign final_char = !item_ff.numbered || (pos_ff == item_ff.len + POS_W'(1));
   assign advance    = item_valid_ff && out_free;
   assign item_done  = advance && final_char;
   assign req_stall  = item_valid_ff && !item_done;
   assign accept     = req_valid && !req_stall;

   always_comb begin
      digit_idx = item_ff.len - POS_W'(1) - pos_ff;
      digit     = 4'd0;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (digit_idx == POS_W'(i)) begin
            digit = item_ff.digits[i];
         end
      end
      if (!item_ff.numbered || pos_ff > item_ff.len) begin
         char = item_ff.in_byte;
      end else if (pos_ff == item_ff.len) begin
         char = TAB_BYTE;
      end else if (pos_ff < item_ff.pad) begin
         char = SPACE_BYTE;
      end else begin
         char = ZERO_CHAR + {4'd0, digit};
      end
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      pos_in        = pos_ff;
      if (!item_valid_ff || item_done) begin
         item_valid_in = accept && item.keep;
         item_in       = item;
         pos_in        = '0;
      end else if (advance) begin
         pos_in = pos_ff + POS_W'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      out_byte_in  = out_byte_ff;
      last_in      = last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = char;
         last_in      = final_char;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pos_ff        <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pos_ff        <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      out_byte_ff <= out_byte_in;
      last_ff     <= last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = last_ff;

endmodule

// ----- design/text_line_number_squeeze_filter.sv -----
// The first transfer of an input byte passes the emitter's item register, then its output
// register. A byte that starts no numbered line is sent as itself; one that starts a numbered
// line is sent as its number, space-padded to max(6, significant digits) characters, a tab and
// the byte, one character a cycle while the output is not stalled; the next byte is taken as
// its last character is sent. A squeezed blank line causes no transfer. Reset is synchronous
// and active high: control registers go to zero, the line counter to one; the block starts at a line start.
`timescale 1ns / 1ps

module text_line_number_squeeze_filter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tlnsf_pkg::PADDR_W-1:0]   paddr,
   input  logic [tlnsf_pkg::PDATA_W-1:0]   pwdata,
   output logic [tlnsf_pkg::PDATA_W-1:0]   prdata,
   output logic                            pready,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_in_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_last
);
   import tlnsf_pkg::*;

   cfg_type  cfg;
   item_type item;
   logic     accept;

   tlnsf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tlnsf_line_state u_line_state (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .accept  (accept),
      .in_byte (req_in_byte),
      .item    (item)
   );

   tlnsf_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .item         (item),
      .accept       (accept),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

// ----- tb/text_line_number_squeeze_filter_tb.sv -----
// Self-checking testbench of the line number and blank squeeze filter, with a scoreboard class.
`timescale 1ns / 1ps

module text_line_number_squeeze_filter_tb;
   import tlnsf_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } out_char_type;

   class numbered_text_board;
      logic [3:0]   count_bcd [COUNT_DIGITS];
      logic         at_start;
      logic         prev_blank;
      logic [1:0]   mode;
      logic         squeeze;
      out_char_type pending_chars [$];
      int           errors;

      function new();
         for (int i = 0; i < COUNT_DIGITS; i++) count_bcd[i] = 4'd0;
         count_bcd[0] = 4'd1;
         at_start = 1'b1;
         prev_blank = 1'b0;
         mode = 2'd0;
         squeeze = 1'b0;
         errors = 0;
      endfunction

      function void set_config(logic [0:0] idx, logic [31:0] value);
         if (idx == REG_NUMBER_MODE) mode = value[1:0];
         else squeeze = value[0];
      endfunction

      function void push_char(logic [7:0] c, logic l);
         out_char_type e;
         e.ch = c;
         e.last = l;
         pending_chars.push_back(e);
      endfunction

      function void take_byte(logic [7:0] b);
         logic is_nl;
         logic blank;
         logic number_it;
         logic carry;
         int   top;
         is_nl = (b == NEWLINE_BYTE);
         blank = at_start && is_nl;
         if (squeeze && blank && prev_blank) return;
         if (at_start) begin
            number_it = mode[1] ? !is_nl : mode[0];
            if (number_it) begin
               top = 0;
               for (int i = 1; i < COUNT_DIGITS; i++) if (count_bcd[i] != 4'd0) top = i;
               for (int k = top + 1; k < MIN_WIDTH; k++) push_char(SPACE_BYTE, 1'b0);
               for (int i = top; i >= 0; i--) push_char(ZERO_CHAR + count_bcd[i], 1'b0);
               push_char(TAB_BYTE, 1'b0);
               carry = 1'b1;
               for (int i = 0; i < COUNT_DIGITS; i++) begin
                  if (carry) begin
                     if (count_bcd[i] >= 4'd9) begin
                        count_bcd[i] = 4'd0;
                     end else begin
                        count_bcd[i] = count_bcd[i] + 4'd1;
                        carry = 1'b0;
                     end
                  end
               end
            end
         end
         push_char(b, 1'b1);
         prev_blank = is_nl ? blank : 1'b0;
         at_start = is_nl;
      endfunction

      function void check_char(logic [7:0] c, logic l);
         out_char_type e;
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected transfer, actual out_byte %h last %b", $time, c, l);
            errors++;
            return;
         end
         e = pending_chars.pop_front();
         if (c !== e.ch) begin
            $display("%0t: out_byte expected %h actual %h", $time, e.ch, c);
            errors++;
         end
         if (l !== e.last) begin
            $display("%0t: last expected %b actual %b", $time, e.last, l);
            errors++;
         end
      endfunction

      function int waiting();
         return pending_chars.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [PADDR_W-1:0]   paddr;
   logic [PDATA_W-1:0]   pwdata;
   logic [PDATA_W-1:0]   prdata;
   logic                 pready;
   logic                 req_valid;
   logic                 req_stall;
   logic [7:0]           req_in_byte;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_last;

   numbered_text_board board;
   int   items_sent;
   int   tx_idle_pct;
   int   rx_idle_pct;
   logic long_hold_req;

   text_line_number_squeeze_filter dut (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int hold_cnt;
      hold_cnt = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_cnt = 120;
            rsp_stall <= 1'b1;
         end else if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall <= 1'b1;
         end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            hold_cnt = $urandom_range(0, 10);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_char(rsp_out_byte, rsp_last);
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      board.take_byte(b);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_line();
      int kind;
      int len;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         len = $urandom_range(1, 4);
         repeat (len) send_byte(NEWLINE_BYTE);
      end else if (kind < 8) begin
         len = $urandom_range(1, 10);
         repeat (len) send_byte(8'($urandom_range(32, 126)));
         send_byte(NEWLINE_BYTE);
      end else if (kind == 8) begin
         len = $urandom_range(1, 6);
         repeat (len) send_byte(8'($urandom_range(0, 255)));
         send_byte(NEWLINE_BYTE);
      end else begin
         len = $urandom_range(1, 5);
         repeat (len) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.waiting() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.set_config(idx, value);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   initial begin
      logic [1:0] phase_mode [7];
      logic       phase_squeeze [7];
      int         target;
      phase_mode = '{2'd2, 2'd0, 2'd1, 2'd3, 2'd1, 2'd2, 2'd0};
      phase_squeeze = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
      board = new();
      items_sent = 0;
      tx_idle_pct = 20;
      rx_idle_pct = 20;
      long_hold_req = 1'b0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_valid = 1'b0;
      req_in_byte = 8'd0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(NEWLINE_BYTE);
      drain();
      write_csr(REG_NUMBER_MODE, 32'd1);
      write_csr(REG_SQUEEZE_EN, 32'd1);
      send_byte(8'h78);
      repeat (4) send_byte(NEWLINE_BYTE);
      send_byte(TAB_BYTE);
      send_byte(SPACE_BYTE);
      send_byte(NEWLINE_BYTE);
      drain();
      write_csr(REG_NUMBER_MODE, 32'd3);
      write_csr(REG_SQUEEZE_EN, 32'd0);
      send_byte(NEWLINE_BYTE);
      send_byte(NEWLINE_BYTE);
      send_byte(8'hAA);
      send_byte(8'h55);
      repeat (3) send_byte(NEWLINE_BYTE);
      drain();

      for (int p = 0; p < 7; p++) begin
         write_csr(REG_NUMBER_MODE, {30'd0, phase_mode[p]});
         write_csr(REG_SQUEEZE_EN, {31'd0, phase_squeeze[p]});
         if (p == 6) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end else begin
            tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
            rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
         end
         target = items_sent + 25;
         while (items_sent < target) begin
            if (p == 2 && items_sent == target - 25) long_hold_req = 1'b1;
            send_random_line();
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.waiting() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/tlnsf_pkg.sv
design/tlnsf_csr.sv
design/tlnsf_line_state.sv
design/tlnsf_emit.sv
design/text_line_number_squeeze_filter.sv
tb/text_line_number_squeeze_filter_tb.sv
